// ----- rtl/smd_pkg.sv -----
package smd_pkg;

  // Item kinds carried by in_action
  typedef enum logic [0:0] {
    ACT_WRITE = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  localparam int CODE_W    = 8;
  localparam int POS_W     = 2;
  localparam int TIME_W    = 32;
  localparam int PAT_W     = 14;
  localparam int DIGITS    = 4;
  localparam int SEG_W     = 7;
  localparam int FONT_LEN  = 75;
  localparam int FONT_IDX_W = 7;

  localparam int TICKS_PER_DIGIT_DEF = 11;

  // Character codes bounding the font and the case fold
  localparam logic [CODE_W-1:0] CODE_FONT_BASE = 8'd48;
  localparam logic [CODE_W-1:0] CODE_FOLD_ABOVE = 8'd90;
  localparam logic [CODE_W-1:0] CODE_FOLD_STEP = 8'd32;

  // Font starting at '0', segment bits a..g = 6..0
  localparam logic [SEG_W-1:0] FONT_TAB [0:FONT_LEN-1] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
    7'h37, 7'h06, 7'h3C, 7'h57, 7'h0E, 7'h55, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B,
    7'h0F, 7'h3E, 7'h1C, 7'h5C, 7'h13, 7'h3B, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C, 7'h57,
    7'h0E, 7'h55, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h1C, 7'h5C,
    7'h13, 7'h3B, 7'h6D
  };

  // Board pin mask for each font segment bit
  localparam logic [PAT_W-1:0] SEG_PIN [0:SEG_W-1] = '{
    14'h0001, 14'h0004, 14'h0200, 14'h0002, 14'h0400, 14'h0010, 14'h0020
  };

  // Digit enable bit in the drive word
  localparam logic [PAT_W-1:0] DIGIT_EN [0:DIGITS-1] = '{
    14'h0100, 14'h0008, 14'h0800, 14'h2000
  };

  // Write port into the pattern store
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] pos;
    logic [PAT_W-1:0] pattern;
  } pat_wr_t;

endpackage

// ----- rtl/seven_segment_mux_driver.sv -----
// Four-digit multiplexed seven-segment display driver.
// Input channel (in_valid / in_stall): an item with in_action write stores the
// glyph of in_char_code for digit in_position and gives no result. An item with
// in_action tick picks digit (in_time_now / TICKS_PER_DIGIT) mod 4 and gives one
// result on the output channel (out_valid / out_stall): the 14-bit shift-register
// drive word, that digit's segment pins ORed with its enable bit.
// Throughput is one item per cycle while in_stall is low. A tick passes through
// three register stages before its drive word shows on out_drive_word:
// input register, reciprocal-multiply register, output register.
// Writes and ticks take effect in order: a tick sees every write accepted
// before it.
// Reset (rst_n low at a clock edge) empties the pipeline and blanks all four
// digits. While out_stall is high a waiting result holds; the pipeline keeps
// filling and raises in_stall only when all stages are full.
module seven_segment_mux_driver #(
  parameter int TICKS_PER_DIGIT = smd_pkg::TICKS_PER_DIGIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [smd_pkg::POS_W-1:0]   in_position,
  input  logic [smd_pkg::CODE_W-1:0]  in_char_code,
  input  logic [smd_pkg::TIME_W-1:0]  in_time_now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smd_pkg::PAT_W-1:0]   out_drive_word
);

  logic                        s1_v_r;
  logic                        s1_action_r;
  logic [smd_pkg::POS_W-1:0]   s1_pos_r;
  logic [smd_pkg::CODE_W-1:0]  s1_code_r;
  logic [smd_pkg::TIME_W-1:0]  s1_time_r;
  logic                        s2_v_r;
  logic                        s2_action_r;
  logic [smd_pkg::POS_W-1:0]   s2_pos_r;
  logic [smd_pkg::PAT_W-1:0]   s2_glyph_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [smd_pkg::PAT_W-1:0]   out_word_r;

  logic                        out_free;
  logic                        s2_tick;
  logic                        s2_go;
  logic                        s2_free;
  logic                        s1_go;
  logic                        s1_free;
  logic                        in_xfer;
  logic [smd_pkg::PAT_W-1:0]   s1_glyph;
  logic [smd_pkg::POS_W-1:0]   s2_idx;
  logic [smd_pkg::PAT_W-1:0]   s2_word;
  smd_pkg::pat_wr_t            pat_wr;

  // Advance a stage when the one after it is empty or moving
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s2_tick  = (s2_action_r == smd_pkg::ACT_TICK);
    s2_go    = s2_v_r && (!s2_tick || out_free);
    s2_free  = !s2_v_r || s2_go;
    s1_go    = s1_v_r && s2_free;
    s1_free  = !s1_v_r || s1_go;
    in_xfer  = in_valid && s1_free;
  end

  assign in_stall = !s1_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r <= in_action;
      s1_pos_r    <= in_position;
      s1_code_r   <= in_char_code;
      s1_time_r   <= in_time_now;
    end
  end

  smd_glyph u_glyph (
    .char_code (s1_code_r),
    .pattern   (s1_glyph)
  );

  smd_digit_phase #(
    .TICKS_PER_DIGIT (TICKS_PER_DIGIT)
  ) u_phase (
    .clk       (clk),
    .load      (s1_go),
    .time_now  (s1_time_r),
    .digit_idx (s2_idx)
  );

  // Second stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_action_r <= s1_action_r;
      s2_pos_r    <= s1_pos_r;
      s2_glyph_r  <= s1_glyph;
    end
  end

  // Commit a write as it leaves the second stage
  always_comb begin
    pat_wr.en      = s2_v_r && !s2_tick;
    pat_wr.pos     = s2_pos_r;
    pat_wr.pattern = s2_glyph_r;
  end

  smd_pattern_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (pat_wr),
    .rd_pos     (s2_idx),
    .rd_pattern (s2_word)
  );

  // Output register: load a tick's word, drop the held one on transfer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s2_go && s2_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_tick) begin
      out_word_r <= s2_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_word = out_word_r;

endmodule

// ----- rtl/smd_glyph.sv -----
module smd_glyph (
  input  logic [smd_pkg::CODE_W-1:0] char_code,
  output logic [smd_pkg::PAT_W-1:0]  pattern
);

  logic [smd_pkg::CODE_W-1:0]     folded;
  logic [smd_pkg::CODE_W-1:0]     offs;
  logic [smd_pkg::FONT_IDX_W-1:0] font_idx;
  logic [smd_pkg::SEG_W-1:0]      seg;
  logic                           blank;

  // Fold lower case to upper case, find the font entry
  always_comb begin
    folded = char_code;
    if (char_code > smd_pkg::CODE_FOLD_ABOVE) begin
      folded = char_code - smd_pkg::CODE_FOLD_STEP;
    end
    offs     = folded - smd_pkg::CODE_FONT_BASE;
    font_idx = offs[smd_pkg::FONT_IDX_W-1:0];
    // High bytes are negative as signed chars, codes below '0' have no glyph
    blank    = char_code[smd_pkg::CODE_W-1] || (folded < smd_pkg::CODE_FONT_BASE);
  end

  // Look up segments, then move each segment bit to its board pin
  always_comb begin
    seg     = blank ? '0 : smd_pkg::FONT_TAB[font_idx];
    pattern = '0;
    for (int j = 0; j < smd_pkg::SEG_W; j++) begin
      if (seg[j]) begin
        pattern = pattern | smd_pkg::SEG_PIN[j];
      end
    end
  end

endmodule

// ----- rtl/smd_digit_phase.sv -----
module smd_digit_phase #(
  parameter int TICKS_PER_DIGIT = smd_pkg::TICKS_PER_DIGIT_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [smd_pkg::TIME_W-1:0]  time_now,
  output logic [smd_pkg::POS_W-1:0]   digit_idx
);

  // floor(2^32 / D): the estimate is the true quotient or one below it
  localparam longint unsigned RecipL = (64'd1 << smd_pkg::TIME_W) / 64'(TICKS_PER_DIGIT);
  localparam int RECIP_W = smd_pkg::TIME_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RecipL[RECIP_W-1:0];
  // Remainder of the estimate stays below 2*D
  localparam int REM_W = $clog2(2 * TICKS_PER_DIGIT);
  localparam int Q_W   = (REM_W > smd_pkg::POS_W) ? REM_W : smd_pkg::POS_W;
  localparam int DIV_W = $clog2(TICKS_PER_DIGIT + 1);
  localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(TICKS_PER_DIGIT);

  logic [smd_pkg::TIME_W+RECIP_W-1:0] prod;
  logic [Q_W-1:0]                     q_est_r;
  logic [REM_W-1:0]                   t_lo_r;
  logic [Q_W+DIV_W-1:0]               back_prod;
  logic [REM_W-1:0]                   rem;
  logic                               fix;

  // Estimate the quotient by reciprocal multiply
  assign prod = time_now * RECIP;

  // Hold the low quotient and time bits for the correction step
  always_ff @(posedge clk) begin
    if (load) begin
      q_est_r <= prod[smd_pkg::TIME_W +: Q_W];
      t_lo_r  <= time_now[REM_W-1:0];
    end
  end

  // Correct the estimate by one where the remainder reaches the divisor
  always_comb begin
    back_prod = q_est_r * DIVISOR;
    rem       = t_lo_r - back_prod[REM_W-1:0];
    fix       = (rem >= REM_W'(TICKS_PER_DIGIT));
    digit_idx = q_est_r[smd_pkg::POS_W-1:0] + smd_pkg::POS_W'(fix);
  end

endmodule

// ----- rtl/smd_pattern_store.sv -----
module smd_pattern_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smd_pkg::pat_wr_t           wr,
  input  logic [smd_pkg::POS_W-1:0]  rd_pos,
  output logic [smd_pkg::PAT_W-1:0]  rd_pattern
);

  logic [smd_pkg::PAT_W-1:0] pat_r [0:smd_pkg::DIGITS-1];

  // Blank all digits at reset, store one digit per write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < smd_pkg::DIGITS; i++) begin
        pat_r[i] <= '0;
      end
    end else if (wr.en) begin
      pat_r[wr.pos] <= wr.pattern;
    end
  end

  // Drive word: stored pattern plus the digit's enable bit
  assign rd_pattern = pat_r[rd_pos] | smd_pkg::DIGIT_EN[rd_pos];

endmodule

// ----- dv/seven_segment_mux_driver_test.sv -----
`timescale 1ns / 100ps

module seven_segment_mux_driver_test;

  localparam int TICK_DIV = 11;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 217;

  // Own copy of the font, from '0' up to 'z', segments a..g on bits 6..0
  localparam logic [6:0] GLYPH_ROM [0:74] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
    7'h37, 7'h06, 7'h3C, 7'h57, 7'h0E, 7'h55, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B,
    7'h0F, 7'h3E, 7'h1C, 7'h5C, 7'h13, 7'h3B, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C, 7'h57,
    7'h0E, 7'h55, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h1C, 7'h5C,
    7'h13, 7'h3B, 7'h6D
  };

  // Board pin for each font segment bit
  localparam logic [13:0] PIN_OF_SEGMENT [0:6] = '{
    14'h0001, 14'h0004, 14'h0200, 14'h0002, 14'h0400, 14'h0010, 14'h0020
  };

  // Enable bit of each digit
  localparam logic [13:0] ENABLE_OF_DIGIT [0:3] = '{
    14'h0100, 14'h0008, 14'h0800, 14'h2000
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_action;
  logic [smd_pkg::POS_W-1:0]    in_position;
  logic [smd_pkg::CODE_W-1:0]   in_char_code;
  logic [smd_pkg::TIME_W-1:0]   in_time_now;
  logic                         out_valid;
  logic                         out_stall;
  logic [smd_pkg::PAT_W-1:0]    out_drive_word;

  // Shadow of the four stored digit patterns and the drive words still due
  logic [smd_pkg::PAT_W-1:0]    shadow_digits [0:3];
  logic [smd_pkg::PAT_W-1:0]    drive_words_due [$];
  logic [smd_pkg::PAT_W-1:0]    next_drive_word;

  int                  error_count;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  holdoff_req;
  int                  holdoff_done;

  seven_segment_mux_driver #(
    .TICKS_PER_DIGIT(TICK_DIV)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_position   (in_position),
    .in_char_code  (in_char_code),
    .in_time_now   (in_time_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_word(out_drive_word)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pattern stored for one character byte
  function automatic logic [smd_pkg::PAT_W-1:0] glyph_pattern(
      input logic [smd_pkg::CODE_W-1:0] code);
    logic [smd_pkg::CODE_W-1:0] c;
    logic [6:0]                 idx;
    logic [6:0]                 seg;
    logic [smd_pkg::PAT_W-1:0]  pat;
    int                         j;
    c = code;
    pat = '0;
    // High bytes are negative as signed char: blank
    if (c[7]) return '0;
    // Fold lower case (and the punctuation after 'Z') down by 32
    if (c > 8'd90) c = c - 8'd32;
    if (c < 8'd48 || c > 8'd122) return '0;
    idx = 7'(c - 8'd48);
    seg = GLYPH_ROM[idx];
    for (j = 0; j < 7; j++) begin
      if (seg[j]) pat = pat | PIN_OF_SEGMENT[j];
    end
    return pat;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Offer one item, wait for its transfer and update the shadow display
  task automatic send_item(input smd_pkg::action_t act,
                           input logic [smd_pkg::POS_W-1:0] pos,
                           input logic [smd_pkg::CODE_W-1:0] code,
                           input logic [smd_pkg::TIME_W-1:0] tnow);
    int                          gap;
    logic [smd_pkg::TIME_W-1:0]  slot;
    logic [1:0]                  digit;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_position  <= pos;
    in_char_code <= code;
    in_time_now  <= tnow;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Transfer happened at this edge
    if (act == smd_pkg::ACT_WRITE) begin
      shadow_digits[pos] = glyph_pattern(code);
    end else begin
      slot = tnow / 32'(TICK_DIV);
      digit = slot[1:0];
      drive_words_due.push_back(shadow_digits[digit] | ENABLE_OF_DIGIT[digit]);
    end
    @(negedge clk);
  endtask

  task automatic write_char(input logic [smd_pkg::POS_W-1:0] pos,
                            input logic [smd_pkg::CODE_W-1:0] code);
    send_item(smd_pkg::ACT_WRITE, pos, code, $urandom);
  endtask

  task automatic tick_at(input logic [smd_pkg::TIME_W-1:0] tnow);
    send_item(smd_pkg::ACT_TICK, smd_pkg::POS_W'($urandom_range(3)),
              smd_pkg::CODE_W'($urandom_range(255)), tnow);
  endtask

  // Drop valid and wait until every drive word due has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (drive_words_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Check each drive word against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected drive word %h", out_drive_word));
      end else begin
        next_drive_word = drive_words_due.pop_front();
        if (out_drive_word !== next_drive_word)
          report_mismatch($sformatf("drive_word got %h want %h",
                                    out_drive_word, next_drive_word));
      end
    end
  end

  // Receiver: random stall, or a long counted hold-off on request
  initial begin
    int k;
    out_stall = 1'b0;
    holdoff_done = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req != holdoff_done) begin
        for (k = 0; k < HOLDOFF_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        holdoff_done++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Blank digits after reset: only the enable bits show
  task automatic test_blank_after_reset();
    tick_at(32'd0);
    tick_at(32'd11);
    tick_at(32'd22);
    tick_at(32'd33);
  endtask

  // Font ends and time extremes
  task automatic test_font_extremes();
    write_char(2'd0, 8'd48);
    write_char(2'd1, 8'd122);
    write_char(2'd2, 8'd90);
    write_char(2'd3, 8'd97);
    tick_at(32'd10);
    tick_at(32'd43);
    tick_at(32'd44);
    tick_at(32'hFFFF_FFFF);
  endtask

  // Low codes, high bytes, empty font entries and folded punctuation
  task automatic test_unmapped_codes();
    write_char(2'd0, 8'd0);
    write_char(2'd1, 8'd128);
    write_char(2'd2, 8'd255);
    write_char(2'd3, 8'd127);
    write_char(2'd0, 8'd58);
    write_char(2'd1, 8'd91);
    write_char(2'd2, 8'd96);
    write_char(2'd3, 8'd47);
    tick_at(32'hFFFF_FFFE);
    tick_at(32'd12);
    tick_at(32'd25);
    tick_at(32'd36);
  endtask

  // Random writes and ticks over all idling phases
  task automatic test_random_traffic();
    int phase;
    int n;
    logic [smd_pkg::CODE_W-1:0] code;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(1) == 1) begin
          if ($urandom_range(1) == 1) tick_at($urandom);
          else tick_at($urandom_range(0, 200));
        end else begin
          case ($urandom_range(3))
            0, 1: code = smd_pkg::CODE_W'($urandom_range(48, 122));
            2: code = smd_pkg::CODE_W'($urandom_range(0, 255));
            default: code = smd_pkg::CODE_W'($urandom_range(91, 127));
          endcase
          write_char(smd_pkg::POS_W'($urandom_range(3)), code);
        end
      end
      wait_drain();
    end
  endtask

  // Hold the receiver off long enough that the pipeline fills and stalls the input
  task automatic test_backpressure_fill();
    int n;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_req++;
    for (n = 0; n < 60; n++) begin
      if (n % 4 == 0)
        write_char(smd_pkg::POS_W'($urandom_range(3)),
                   smd_pkg::CODE_W'($urandom_range(48, 122)));
      else tick_at($urandom);
    end
    wait_drain();
  endtask

  initial begin
    int i;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = smd_pkg::ACT_WRITE;
    in_position = '0;
    in_char_code = '0;
    in_time_now = '0;
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_req = 0;
    for (i = 0; i < 4; i++) shadow_digits[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_blank_after_reset();
    test_font_extremes();
    test_unmapped_codes();
    test_random_traffic();
    test_backpressure_fill();

    // Let the last drive words arrive
    stall_pct = 0;
    wait_drain();
    if (error_count == 0 && drive_words_due.size() == 0) begin
      $display("seven_segment_mux_driver: match");
    end else begin
      $display("seven_segment_mux_driver: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("seven_segment_mux_driver: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/smd_pkg.sv
rtl/smd_glyph.sv
rtl/smd_digit_phase.sv
rtl/smd_pattern_store.sv
rtl/seven_segment_mux_driver.sv
dv/seven_segment_mux_driver_test.sv
